// File: rtl/htd_pkg.sv
// htd_pkg: shared types and codes of the huffman tree decoder
// no dependencies; used by the top level, front, queue and back files
package htd_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_NODE  = 2'd1,
        OP_START = 2'd2,
        OP_DIGIT = 2'd3
    } op_t;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_NODE,
        CMD_START,
        CMD_BITS
    } cmd_kind_t;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // command word: bits are decoded msb first from bits[7]
    typedef struct packed {
        cmd_kind_t   kind;
        logic        is_leaf;
        logic [7:0]  sym;
        logic [7:0]  bits;
        logic [3:0]  nbits;
        logic        end_walk;
    } cmd_t;

    typedef struct packed {
        logic        symbol_valid;
        logic [7:0]  symbol;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NODE_PAR,
        BK_POP,
        BK_DECODE,
        BK_FLUSH
    } back_state_t;

endpackage

// File: rtl/htd_if.sv
// htd_if: valid/ready channel interfaces of the huffman tree decoder
// no dependencies
interface htd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        node_is_leaf;
    logic [7:0]  leaf_symbol;
    logic [2:0]  pad_bits;
    logic [3:0]  hex_digit;
    logic        last_digit;

    modport source (output valid, output operation, output node_is_leaf,
                    output leaf_symbol, output pad_bits, output hex_digit,
                    output last_digit, input ready);
    modport sink (input valid, input operation, input node_is_leaf,
                  input leaf_symbol, input pad_bits, input hex_digit,
                  input last_digit, output ready);
endinterface

interface htd_out_if;
    logic        valid;
    logic        ready;
    logic        symbol_valid;
    logic [7:0]  symbol;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output symbol_valid, output symbol,
                    output status, output last, input ready);
    modport sink (input valid, input symbol_valid, input symbol,
                  input status, input last, output ready);
endinterface

// File: rtl/huffman_tree_decoder.sv
// huffman_tree_decoder: top level, front classifier, command queue and walk engine
// depends on htd_pkg, htd_if, htd_front, htd_queue, htd_back
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    operation, node_is_leaf, leaf_symbol, pad_bits,
//                                  hex_digit, last_digit
//   out_ch    out   valid/ready    symbol_valid, symbol, status, last
//
// a tree node item in the back end: node write, then right link and stack pop as needed
// a hex digit is walked one coded bit at a time, with a dependent read of the node memory
// for each step of the walk
// the front takes an item every cycle while the two-entry queue has room
// reset is asynchronous, active low; tree and walk come up empty, no clearing pass
// a stalled output holds the back end only when it has a new result to deliver
module huffman_tree_decoder #(
    parameter int NODES       = 1024,
    parameter int STACK_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    htd_in_if.sink    in_ch,
    htd_out_if.source out_ch
);
    htd_pkg::cmd_t  front_cmd;
    logic           front_valid;
    logic           front_ready;
    htd_pkg::cmd_t  back_cmd;
    logic           back_valid;
    logic           back_ready;

    htd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(front_cmd), .cmd_valid(front_valid), .cmd_ready(front_ready)
    );

    htd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_cmd(front_cmd), .in_valid(front_valid), .in_ready(front_ready),
        .out_cmd(back_cmd), .out_valid(back_valid), .out_ready(back_ready)
    );

    htd_back #(.NODES(NODES), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd(back_cmd), .cmd_valid(back_valid), .cmd_ready(back_ready),
        .out_ch(out_ch)
    );
endmodule

// File: rtl/htd_ram.sv
// htd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/htd_front.sv
// htd_front: accepts input items, keeps held digit and pad count, emits commands
// depends on htd_pkg and htd_if
module htd_front (
    input  logic            clk,
    input  logic            rst_n,
    htd_in_if.sink          in_ch,
    output htd_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    logic [3:0]      held_digit_reg, held_digit_next;
    logic            held_valid_reg, held_valid_next;
    logic [2:0]      pad_count_reg, pad_count_next;
    logic            need_cmd;
    logic            accept;
    logic [3:0]      total_bits;
    logic [3:0]      pad_ext;
    htd_pkg::op_t    op;

    assign in_ch.ready = cmd_ready;
    assign accept      = in_ch.valid && cmd_ready;
    assign cmd_valid   = in_ch.valid && need_cmd;
    assign op          = htd_pkg::op_t'(in_ch.operation);
    assign pad_ext     = {1'b0, pad_count_reg};
    assign total_bits  = held_valid_reg ? 4'd8 : 4'd4;

    // classify the item and build its command
    always_comb
    begin
        need_cmd        = 1'b1;
        held_digit_next = held_digit_reg;
        held_valid_next = held_valid_reg;
        pad_count_next  = pad_count_reg;
        cmd.kind        = htd_pkg::CMD_CLEAR;
        cmd.is_leaf     = in_ch.node_is_leaf;
        cmd.sym         = in_ch.leaf_symbol;
        cmd.bits        = {held_digit_reg, 4'd0};
        cmd.nbits       = 4'd4;
        cmd.end_walk    = 1'b0;
        case (op)
            htd_pkg::OP_CLEAR:
            begin
                cmd.kind        = htd_pkg::CMD_CLEAR;
                held_digit_next = 4'd0;
                held_valid_next = 1'b0;
            end
            htd_pkg::OP_NODE:
            begin
                cmd.kind = htd_pkg::CMD_NODE;
            end
            htd_pkg::OP_START:
            begin
                cmd.kind        = htd_pkg::CMD_START;
                pad_count_next  = in_ch.pad_bits;
                held_digit_next = 4'd0;
                held_valid_next = 1'b0;
            end
            htd_pkg::OP_DIGIT:
            begin
                cmd.kind = htd_pkg::CMD_BITS;
                if (!in_ch.last_digit)
                begin
                    // decode the held digit, hold the new one
                    need_cmd        = held_valid_reg;
                    held_digit_next = in_ch.hex_digit;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    // final digits with padding trimmed
                    cmd.bits     = held_valid_reg ? {held_digit_reg, in_ch.hex_digit}
                                                  : {in_ch.hex_digit, 4'd0};
                    cmd.nbits    = (pad_ext >= total_bits) ? 4'd0 : total_bits - pad_ext;
                    cmd.end_walk = 1'b1;
                    held_digit_next = 4'd0;
                    held_valid_next = 1'b0;
                end
            end
            default:
            begin
                need_cmd = 1'b0;
            end
        endcase
    end

    // held digit and pad state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_digit_reg <= 4'd0;
            held_valid_reg <= 1'b0;
            pad_count_reg  <= 3'd0;
        end
        else if (accept)
        begin
            held_digit_reg <= held_digit_next;
            held_valid_reg <= held_valid_next;
            pad_count_reg  <= pad_count_next;
        end
    end
endmodule

// File: rtl/htd_queue.sv
// htd_queue: two-entry command queue between front and back
// depends on htd_pkg
module htd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  htd_pkg::cmd_t   in_cmd,
    input  logic            in_valid,
    output logic            in_ready,
    output htd_pkg::cmd_t   out_cmd,
    output logic            out_valid,
    input  logic            out_ready
);
    htd_pkg::cmd_t  entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/htd_back.sv
// htd_back: tree build into node memory and bit-by-bit tree walk
// depends on htd_pkg, htd_if and htd_ram
module htd_back #(
    parameter int NODES       = 1024,
    parameter int STACK_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  htd_pkg::cmd_t   cmd,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    htd_out_if.source       out_ch
);
    localparam int AW  = $clog2(NODES);
    localparam int CW  = $clog2(NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    // node word: leaf, symbol, right valid, right child (left child is index + 1)
    localparam int WW  = AW + 10;

    htd_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [AW-1:0]   top_idx_reg, top_idx_next;
    logic            top_ld_reg, top_ld_next;
    logic [AW-1:0]   new_idx_reg, new_idx_next;
    logic            new_leaf_reg, new_leaf_next;
    logic [AW-1:0]   cur_idx_reg, cur_idx_next;
    logic [WW-1:0]   cur_word_reg, cur_word_next;
    logic [WW-1:0]   root_word_reg, root_word_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;
    logic [7:0]      bits_reg, bits_next;
    logic [3:0]      nbits_reg, nbits_next;
    logic            end_walk_reg, end_walk_next;
    htd_pkg::result_t res_reg, res_next;
    logic            res_valid_reg, res_valid_next;
    htd_pkg::result_t out_reg, out_next;
    logic            out_last_reg, out_last_next;
    logic            out_valid_reg, out_valid_next;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [WW-1:0]   mem_wdata, mem_rdata;
    logic            stk_we, stk_re;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [AW-1:0]   stk_wdata, stk_rdata;

    logic            right_link, tree_done, node_full, out_free, slot_ok;
    logic [DW-1:0]   depth_after, depth_dec, depth_dec2;
    logic [WW-1:0]   eff_word;
    logic [AW-1:0]   eff_idx, child_idx;
    logic [CW-1:0]   left_idx;
    logic            left_ok, right_ok, child_ok, cur_bit, tree_usable;
    logic            want_emit;
    htd_pkg::result_t emit_res;

    htd_ram #(.WIDTH(WW), .DEPTH(NODES)) u_node_ram (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    htd_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // build checks
    assign right_link  = (depth_reg != '0) && top_ld_reg;
    assign depth_after = depth_reg - DW'(right_link);
    assign depth_dec   = depth_reg - DW'(1);
    assign depth_dec2  = depth_reg - DW'(2);
    assign tree_done   = (count_reg != '0) && (depth_reg == '0);
    assign node_full   = (count_reg >= CW'(NODES)) ||
                         (!cmd.is_leaf && (depth_after >= DW'(STACK_DEPTH)));
    assign tree_usable = (count_reg != '0) && !root_word_reg[WW-1];

    // walk step from the current node or the node just read
    assign eff_word  = pend_reg ? mem_rdata : cur_word_reg;
    assign eff_idx   = pend_reg ? pend_idx_reg : cur_idx_reg;
    assign cur_bit   = bits_reg[7];
    assign left_idx  = CW'(eff_idx) + CW'(1);
    assign left_ok   = left_idx < count_reg;
    assign right_ok  = eff_word[AW] && (CW'(eff_word[AW-1:0]) < count_reg);
    assign child_ok  = cur_bit ? right_ok : left_ok;
    assign child_idx = cur_bit ? eff_word[AW-1:0] : left_idx[AW-1:0];

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign slot_ok   = !res_valid_reg || out_free;

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        depth_next     = depth_reg;
        top_idx_next   = top_idx_reg;
        top_ld_next    = top_ld_reg;
        new_idx_next   = new_idx_reg;
        new_leaf_next  = new_leaf_reg;
        cur_idx_next   = cur_idx_reg;
        cur_word_next  = cur_word_reg;
        root_word_next = root_word_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        bits_next      = bits_reg;
        nbits_next     = nbits_reg;
        end_walk_next  = end_walk_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = child_idx;
        stk_we         = 1'b0;
        stk_waddr      = depth_dec[SAW-1:0];
        stk_wdata      = top_idx_reg;
        stk_re         = 1'b0;
        stk_raddr      = depth_dec2[SAW-1:0];
        want_emit      = 1'b0;
        emit_res       = '{symbol_valid: 1'b0, symbol: 8'd0, status: htd_pkg::ST_OK};

        case (state_reg)
            htd_pkg::BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        htd_pkg::CMD_CLEAR:
                        begin
                            count_next    = '0;
                            depth_next    = '0;
                            cur_idx_next  = '0;
                            cur_word_next = root_word_reg;
                            pend_next     = 1'b0;
                        end
                        htd_pkg::CMD_START:
                        begin
                            cur_idx_next  = '0;
                            cur_word_next = root_word_reg;
                        end
                        htd_pkg::CMD_NODE:
                        begin
                            if (tree_done)
                            begin
                                state_next = htd_pkg::BK_IDLE;
                            end
                            else if (node_full)
                            begin
                                res_next = '{symbol_valid: 1'b0, symbol: 8'd0,
                                             status: htd_pkg::ST_FULL};
                                res_valid_next = 1'b1;
                                state_next     = htd_pkg::BK_FLUSH;
                            end
                            else
                            begin
                                // append the node
                                mem_we       = 1'b1;
                                mem_waddr    = count_reg[AW-1:0];
                                mem_wdata    = {cmd.is_leaf,
                                                cmd.is_leaf ? cmd.sym : 8'd0,
                                                1'b0, AW'(0)};
                                count_next   = count_reg + CW'(1);
                                new_idx_next = count_reg[AW-1:0];
                                new_leaf_next = cmd.is_leaf;
                                if (depth_reg == '0)
                                begin
                                    if (!cmd.is_leaf)
                                    begin
                                        top_idx_next = count_reg[AW-1:0];
                                        top_ld_next  = 1'b0;
                                        depth_next   = DW'(1);
                                    end
                                end
                                else if (!top_ld_reg)
                                begin
                                    // left link is implicit
                                    top_ld_next = 1'b1;
                                    if (!cmd.is_leaf)
                                    begin
                                        stk_we       = 1'b1;
                                        top_idx_next = count_reg[AW-1:0];
                                        top_ld_next  = 1'b0;
                                        depth_next   = depth_reg + DW'(1);
                                    end
                                end
                                else
                                begin
                                    state_next = htd_pkg::BK_NODE_PAR;
                                end
                            end
                        end
                        htd_pkg::CMD_BITS:
                        begin
                            if (!tree_usable)
                            begin
                                if (cmd.end_walk)
                                begin
                                    cur_idx_next  = '0;
                                    cur_word_next = root_word_reg;
                                end
                            end
                            else
                            begin
                                bits_next     = cmd.bits;
                                nbits_next    = cmd.nbits;
                                end_walk_next = cmd.end_walk;
                                pend_next     = 1'b0;
                                state_next    = htd_pkg::BK_DECODE;
                            end
                        end
                        default:
                        begin
                            state_next = htd_pkg::BK_IDLE;
                        end
                    endcase
                end
            end

            htd_pkg::BK_NODE_PAR:
            begin
                // right link into the stack top; an inner child becomes the new top, a leaf child pops
                mem_we    = 1'b1;
                mem_waddr = top_idx_reg;
                mem_wdata = {1'b0, 8'd0, 1'b1, new_idx_reg};
                state_next = htd_pkg::BK_IDLE;
                if (!new_leaf_reg)
                begin
                    top_idx_next = new_idx_reg;
                    top_ld_next  = 1'b0;
                end
                else
                begin
                    depth_next = depth_dec;
                    if (depth_reg > DW'(1))
                    begin
                        stk_re     = 1'b1;
                        state_next = htd_pkg::BK_POP;
                    end
                end
            end

            htd_pkg::BK_POP:
            begin
                top_idx_next = stk_rdata;
                top_ld_next  = 1'b1;
                state_next   = htd_pkg::BK_IDLE;
            end

            htd_pkg::BK_DECODE:
            begin
                if (pend_reg && eff_word[WW-1])
                begin
                    // leaf reached
                    want_emit = 1'b1;
                    emit_res  = '{symbol_valid: 1'b1, symbol: eff_word[WW-2:WW-9],
                                  status: htd_pkg::ST_OK};
                    if (slot_ok)
                    begin
                        pend_next     = 1'b0;
                        cur_idx_next  = '0;
                        cur_word_next = root_word_reg;
                    end
                end
                else if (nbits_reg != 4'd0)
                begin
                    if (!child_ok)
                    begin
                        want_emit = 1'b1;
                        emit_res  = '{symbol_valid: 1'b0, symbol: 8'd0,
                                      status: htd_pkg::ST_MISSING};
                        if (slot_ok)
                        begin
                            pend_next     = 1'b0;
                            cur_idx_next  = '0;
                            cur_word_next = root_word_reg;
                            bits_next     = {bits_reg[6:0], 1'b0};
                            nbits_next    = nbits_reg - 4'd1;
                        end
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        pend_next     = 1'b1;
                        pend_idx_next = child_idx;
                        bits_next     = {bits_reg[6:0], 1'b0};
                        nbits_next    = nbits_reg - 4'd1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (end_walk_reg)
                    begin
                        cur_idx_next  = '0;
                        cur_word_next = root_word_reg;
                    end
                    else if (pend_reg)
                    begin
                        cur_idx_next  = pend_idx_reg;
                        cur_word_next = mem_rdata;
                    end
                    state_next = res_valid_reg ? htd_pkg::BK_FLUSH : htd_pkg::BK_IDLE;
                end
            end

            htd_pkg::BK_FLUSH:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    res_valid_next = 1'b0;
                    state_next     = htd_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = htd_pkg::BK_IDLE;
            end
        endcase

        // new result enters the slot, older one moves out as not last
        if (want_emit && slot_ok)
        begin
            if (res_valid_reg)
            begin
                out_next       = res_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            res_next       = emit_res;
            res_valid_next = 1'b1;
        end

        // keep cached node words coherent with memory writes
        if (mem_we && (mem_waddr == cur_idx_reg))
        begin
            cur_word_next = mem_wdata;
        end
        if (mem_we && (mem_waddr == '0))
        begin
            root_word_next = mem_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htd_pkg::BK_IDLE;
            count_reg     <= '0;
            depth_reg     <= '0;
            top_ld_reg    <= 1'b0;
            cur_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            nbits_reg     <= 4'd0;
            end_walk_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            depth_reg     <= depth_next;
            top_ld_reg    <= top_ld_next;
            cur_idx_reg   <= cur_idx_next;
            pend_reg      <= pend_next;
            nbits_reg     <= nbits_next;
            end_walk_reg  <= end_walk_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_idx_reg   <= top_idx_next;
        new_idx_reg   <= new_idx_next;
        new_leaf_reg  <= new_leaf_next;
        cur_word_reg  <= cur_word_next;
        root_word_reg <= root_word_next;
        pend_idx_reg  <= pend_idx_next;
        bits_reg      <= bits_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.symbol_valid = out_reg.symbol_valid;
    assign out_ch.symbol       = out_reg.symbol;
    assign out_ch.status       = out_reg.status;
    assign out_ch.last         = out_last_reg;

    // build stack never exceeds its capacity
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("build stack depth beyond capacity");

    // node count never exceeds the node memory
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NODES))
        else $error("node count beyond node memory");

    // a pop always follows a right link
    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htd_pkg::BK_POP) |-> ($past(state_reg) == htd_pkg::BK_NODE_PAR))
        else $error("stack pop without right link");

    // commands are taken only with no result waiting in the slot
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> !res_valid_reg)
        else $error("command taken with a pending result");
endmodule
